[rtl/circular_deque_core_defines.svh]
// assertion macros used by the deque controller rtl
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, checked out of reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`else

`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/dq_pkg.sv]
// shared types and codes for the circular deque
// no dependencies; imported by every deque module
package dq_pkg;

  localparam int WORD_W = 32;

  // operation codes carried by an input transfer
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  // restriction mode register values (three behaves as unrestricted)
  localparam logic [1:0] MODE_FREE      = 2'd0;
  localparam logic [1:0] MODE_IN_RESTR  = 2'd1;
  localparam logic [1:0] MODE_OUT_RESTR = 2'd2;

  // register index of the mode register on the config port
  localparam logic REG_IDX_MODE = 1'b0;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SEEK = 1'b1
  } fsm_state_t;

  // write request from the controller into the cell ring
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] data;
  } ring_wr_t;

endpackage

[rtl/dq_if.sv]
// valid/ready channel interfaces for the deque input and result streams
// depends on nothing but the fixed field widths
interface dq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_out_if #(
  parameter int CNT_W = 4
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] pop_value;
  logic [CNT_W-1:0]   count;
  logic               is_empty;
  logic               is_full;

  modport source (
    output valid, output status, output pop_value, output count,
    output is_empty, output is_full, input ready
  );
  modport sink (
    input valid, input status, input pop_value, input count,
    input is_empty, input is_full, output ready
  );
endinterface

[rtl/dq_cell.sv]
// one storage cell of the rotating slot ring
// depends on dq_pkg for the word width
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic [WORD_W-1:0] shift_in,
  input  logic              wr_en,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] data_out
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // take the neighbour's word, or the new word on a write
  assign data_nxt = wr_en ? wr_data : shift_in;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

[rtl/dq_ring.sv]
// ring of dq_cell instances rotating one place per cycle, with its phase counter
// depends on dq_pkg and dq_cell
module dq_ring
  import dq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int PTR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ring_wr_t          ring_wr,
  output logic [PTR_W-1:0]  phase,
  output logic [WORD_W-1:0] tap_data
);

  logic [WORD_W-1:0] cell_q [DEPTH];
  logic [PTR_W-1:0]  phase_r;
  logic [PTR_W-1:0]  phase_nxt;

  // phase: slot index currently sitting in cell 0
  assign phase_nxt = (phase_r == PTR_W'(DEPTH - 1)) ? '0 : phase_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // cell i holds slot (phase + i) mod depth; the tap word re-enters at the far end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      dq_cell u_cell (
        .clk      (clk),
        .shift_in (cell_q[0]),
        .wr_en    (ring_wr.en),
        .wr_data  (ring_wr.data),
        .data_out (cell_q[i])
      );
    end else begin : g_mid
      dq_cell u_cell (
        .clk      (clk),
        .shift_in (cell_q[i+1]),
        .wr_en    (1'b0),
        .wr_data  (ring_wr.data),
        .data_out (cell_q[i])
      );
    end
  end

  assign phase    = phase_r;
  assign tap_data = cell_q[0];

endmodule

[rtl/dq_ctrl.sv]
// deque controller: head/tail pointers, operation decode, slot wait and result register
// depends on dq_pkg and the assertion macros header
`include "circular_deque_core_defines.svh"

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int PTR_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               mode,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_push_value,
  input  logic [PTR_W-1:0]         phase,
  input  logic [WORD_W-1:0]        tap_data,
  output ring_wr_t                 ring_wr,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_pop_value,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  // pointer helpers, wrapping at the depth
  function automatic logic [PTR_W-1:0] step_fwd(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_of(input logic [PTR_W-1:0] h,
                                                input logic [PTR_W-1:0] t,
                                                input logic             e);
    logic [CNT_W-1:0] hx;
    logic [CNT_W-1:0] tx;
    logic [CNT_W-1:0] diff;
    hx   = CNT_W'(h);
    tx   = CNT_W'(t);
    diff = (tx >= hx) ? tx - hx : tx + CNT_W'(DEPTH) - hx;
    return e ? '0 : diff + CNT_W'(1);
  endfunction

  fsm_state_t state_r, state_nxt;

  // latched item while waiting for its slot
  opcode_t            op_r;
  logic [WORD_W-1:0]  word_r;
  logic [PTR_W-1:0]   target_r;
  status_t            stat_r;

  // deque pointers
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;

  // result register
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [WORD_W-1:0] out_pop_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_empty_r;
  logic                     out_full_r;

  logic [CNT_W-1:0]  cur_count;
  logic              cur_full;
  opcode_t           in_op;
  logic              in_push;
  logic              rejected;
  status_t           dec_status;
  logic [PTR_W-1:0]  dec_target;

  opcode_t           item_op;
  logic [WORD_W-1:0] item_word;
  logic [PTR_W-1:0]  item_target;
  status_t           item_status;
  logic              item_go;
  logic              item_push;
  logic              item_ok;
  logic              out_free;
  logic              done;
  logic              ok_push;
  logic              ok_pop;
  logic [WORD_W-1:0] pop_word;

  // decode of the incoming transfer against the current state
  assign cur_count = count_of(head_r, tail_r, empty_r);
  assign cur_full  = (cur_count == CNT_W'(DEPTH));
  assign in_op     = opcode_t'(in_opcode);
  assign in_push   = (in_op == OP_PUSH_FRONT) || (in_op == OP_PUSH_REAR);
  assign rejected  = ((mode == MODE_IN_RESTR) && (in_op == OP_PUSH_REAR)) ||
                     ((mode == MODE_OUT_RESTR) && (in_op == OP_POP_FRONT));

  always_comb begin
    if (rejected) begin
      dec_status = ST_REJECTED;
    end else if (in_push && cur_full) begin
      dec_status = ST_OVERFLOW;
    end else if (!in_push && empty_r) begin
      dec_status = ST_UNDERFLOW;
    end else begin
      dec_status = ST_OK;
    end
  end

  // slot that the operation touches
  always_comb begin
    case (in_op)
      OP_PUSH_FRONT: dec_target = empty_r ? '0 : step_back(head_r);
      OP_PUSH_REAR:  dec_target = empty_r ? '0 : step_fwd(tail_r);
      OP_POP_FRONT:  dec_target = head_r;
      OP_POP_REAR:   dec_target = tail_r;
      default:       dec_target = head_r;
    endcase
  end

  // the item in hand: fresh transfer when idle, latched one while seeking
  assign item_op     = (state_r == S_IDLE) ? in_op : op_r;
  assign item_word   = (state_r == S_IDLE) ? in_push_value : word_r;
  assign item_target = (state_r == S_IDLE) ? dec_target : target_r;
  assign item_status = (state_r == S_IDLE) ? dec_status : stat_r;
  assign item_go     = (state_r == S_IDLE) ? in_valid : 1'b1;
  assign item_push   = (item_op == OP_PUSH_FRONT) || (item_op == OP_PUSH_REAR);
  assign item_ok     = (item_status == ST_OK);
  assign out_free    = !out_valid_r || out_ready;
  assign done        = item_go && out_free && (!item_ok || (phase == item_target));
  assign ok_push     = done && item_ok && item_push;
  assign ok_pop      = done && item_ok && !item_push;
  assign in_ready    = (state_r == S_IDLE);

  // state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !done) begin
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the item while it waits for its slot
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      op_r     <= in_op;
      word_r   <= in_push_value;
      target_r <= dec_target;
      stat_r   <= dec_status;
    end
  end

  // pointer update on completion of a good operation
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    if (done && item_ok) begin
      case (item_op)
        OP_PUSH_FRONT: begin
          empty_nxt = 1'b0;
          if (empty_r) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = step_back(head_r);
          end
        end
        OP_PUSH_REAR: begin
          empty_nxt = 1'b0;
          if (empty_r) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            tail_nxt = step_fwd(tail_r);
          end
        end
        OP_POP_FRONT: begin
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
          end else begin
            head_nxt = step_fwd(head_r);
          end
        end
        OP_POP_REAR: begin
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
          end else begin
            tail_nxt = step_back(tail_r);
          end
        end
        default: begin
          empty_nxt = empty_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // slot write as the target slot passes the tap
  assign ring_wr.en   = ok_push;
  assign ring_wr.data = item_word;
  assign pop_word     = ok_pop ? tap_data : '0;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= item_status;
      out_pop_r    <= pop_word;
      out_count_r  <= count_of(head_nxt, tail_nxt, empty_nxt);
      out_empty_r  <= empty_nxt;
      out_full_r   <= (count_of(head_nxt, tail_nxt, empty_nxt) == CNT_W'(DEPTH));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = out_pop_r;
  assign out_count     = out_count_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;

  // checks
  `DQ_ASSERT_NOW(a_empty_ptrs, clk, rst_n, empty_r, head_r == tail_r)
  `DQ_ASSERT_NEXT(a_push_count, clk, rst_n, ok_push, out_count_r == $past(cur_count) + CNT_W'(1))
  `DQ_ASSERT_NEXT(a_pop_count, clk, rst_n, ok_pop, out_count_r == $past(cur_count) - CNT_W'(1))
  `DQ_ASSERT_NOW(a_fail_no_data, clk, rst_n, out_valid_r && (out_status_r != ST_OK), out_pop_r == '0)

endmodule

[rtl/circular_deque_core.sv]
// top level of the circular deque: config register, cell ring and controller
// depends on dq_pkg, dq_if, dq_ring, dq_ctrl
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in_if    | sink      | valid/ready transfer | opcode, push_value
//  out_if   | source    | valid/ready transfer | status, pop_value, count, is_empty, is_full
//  cfg_*    | slave     | apb write/read       | restrict_mode at byte address 0
//
// one item is in flight at a time; a rejected, overflowing or underflowing item
// completes in the cycle it is transferred if the result register is free, a good push
// or pop waits until its slot rotates to the ring tap, as tracked by the ring phase counter.
// rst_n is synchronous, active low; it clears pointers, mode and handshake state,
// slot cells are not cleared. a held result does not block the next transfer in;
// that item waits in the controller until the result register drains.
module circular_deque_core
  import dq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  dq_in_if.sink        in_if,
  dq_out_if.source     out_if,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [1:0]         mode_r;
  logic [1:0]         mode_nxt;
  logic               cfg_wr;
  ring_wr_t           ring_wr;
  logic [PTR_W-1:0]   phase;
  logic [WORD_W-1:0]  tap_data;
  logic [CNT_W-1:0]   out_count;

  // config register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_IDX_MODE);
  assign mode_nxt   = cfg_wr ? cfg_pwdata[1:0] : mode_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FREE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // rotating slot store
  dq_ring #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ring_wr  (ring_wr),
    .phase    (phase),
    .tap_data (tap_data)
  );

  // pointers, decode and result register
  dq_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_opcode     (in_if.opcode),
    .in_push_value (in_if.push_value),
    .phase         (phase),
    .tap_data      (tap_data),
    .ring_wr       (ring_wr),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_status    (out_if.status),
    .out_pop_value (out_if.pop_value),
    .out_count     (out_count),
    .out_is_empty  (out_if.is_empty),
    .out_is_full   (out_if.is_full)
  );

  assign out_if.count = out_count;

endmodule

[tb/circular_deque_core_tb.sv]
// self-checking testbench for circular_deque_core: shadow deque predicts every result
// depends on dq_pkg, the dq_in_if/dq_out_if channel interfaces and the deque rtl
`timescale 1ns / 1ps

module circular_deque_core_tb;
  import dq_pkg::*;

  localparam int DEPTH         = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 215;
  localparam int MAX_PRINTS    = 40;

  // the fourth mode encoding, treated by the block as unrestricted
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [2:0] MODE_ADDR  = {REG_IDX_MODE, 2'b00};

  typedef struct {
    opcode_t            op;
    logic signed [31:0] word;
  } deque_op_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] pop_value;
    logic [3:0]         count;
    logic               is_empty;
    logic               is_full;
  } deque_outcome_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dq_in_if             in_ch ();
  dq_out_if #(.CNT_W(4)) out_ch ();

  circular_deque_core #(.DEPTH(DEPTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow copy of the deque and its mode register
  logic signed [31:0] shadow_slots [DEPTH];
  int                 shadow_head;
  int                 shadow_tail;
  logic               shadow_empty;
  logic [1:0]         shadow_mode;

  deque_op_t      op_backlog [$];
  deque_outcome_t predicted_outcomes [$];

  int queued_total;
  int accepted_total;
  int results_checked;
  int mismatches;
  int prints;
  int cycle_count;
  int mode_writes;
  int status_tally [4];
  int src_gap;
  int sink_stall;
  int sink_draw;
  bit src_idle_on;
  bit sink_idle_on;
  deque_op_t drv_item;
  deque_outcome_t want;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    mismatches++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("mismatch at result %0d: %s expected %0h got %0h", results_checked, what,
               exp_val, got_val);
    end
  endtask

  function automatic int shadow_count();
    if (shadow_empty) return 0;
    return ((shadow_tail + DEPTH - shadow_head) % DEPTH) + 1;
  endfunction

  // apply one operation to the shadow deque and return the result it gives
  function automatic deque_outcome_t step_shadow_deque(opcode_t op, logic signed [31:0] word);
    deque_outcome_t res;
    int cnt;
    res.status    = ST_OK;
    res.pop_value = '0;
    cnt = shadow_count();
    if ((shadow_mode == MODE_IN_RESTR && op == OP_PUSH_REAR) ||
        (shadow_mode == MODE_OUT_RESTR && op == OP_POP_FRONT)) begin
      res.status = ST_REJECTED;
    end else if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (cnt >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else if (shadow_empty) begin
        // first entry always lands in slot zero
        shadow_head     = 0;
        shadow_tail     = 0;
        shadow_slots[0] = word;
        shadow_empty    = 1'b0;
      end else if (op == OP_PUSH_FRONT) begin
        shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
        shadow_slots[shadow_head] = word;
      end else begin
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_slots[shadow_tail] = word;
      end
    end else begin
      if (shadow_empty) begin
        res.status = ST_UNDERFLOW;
      end else if (op == OP_POP_FRONT) begin
        res.pop_value = shadow_slots[shadow_head];
        if (shadow_head == shadow_tail) shadow_empty = 1'b1;
        else shadow_head = (shadow_head + 1) % DEPTH;
      end else begin
        res.pop_value = shadow_slots[shadow_tail];
        if (shadow_head == shadow_tail) shadow_empty = 1'b1;
        else shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
      end
    end
    cnt = shadow_count();
    res.count    = 4'(cnt);
    res.is_empty = shadow_empty;
    res.is_full  = (cnt == DEPTH);
    return res;
  endfunction

  // input side: one item from the backlog per transfer, random gap after each when idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.opcode     <= OP_PUSH_FRONT;
      in_ch.push_value <= '0;
      src_gap          <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (op_backlog.size() > 0) begin
        drv_item          = op_backlog.pop_front();
        in_ch.opcode     <= drv_item.op;
        in_ch.push_value <= drv_item.word;
        in_ch.valid      <= 1'b1;
        src_gap          <= src_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random stall after each transfer when idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      sink_draw     = sink_idle_on ? $urandom_range(0, 10) : 0;
      sink_stall   <= sink_draw;
      out_ch.ready <= (sink_draw == 0);
    end else if (!out_ch.ready) begin
      if (sink_stall <= 1) out_ch.ready <= 1'b1;
      if (sink_stall > 0) sink_stall <= sink_stall - 1;
    end
  end

  // monitor: predict on every input transfer, then check every result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_outcomes = {predicted_outcomes,
                              step_shadow_deque(opcode_t'(in_ch.opcode), in_ch.push_value)};
        accepted_total++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (predicted_outcomes.size() == 0) begin
          report_mismatch("result with nothing awaited", '0, '0);
        end else begin
          want = predicted_outcomes.pop_front();
          status_tally[want.status]++;
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_ch.status));
          if (out_ch.pop_value !== want.pop_value)
            report_mismatch("pop_value", want.pop_value, out_ch.pop_value);
          if (out_ch.count !== want.count)
            report_mismatch("count", 32'(want.count), 32'(out_ch.count));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(want.is_empty), 32'(out_ch.is_empty));
          if (out_ch.is_full !== want.is_full)
            report_mismatch("is_full", 32'(want.is_full), 32'(out_ch.is_full));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               predicted_outcomes.size());
      $display("circular_deque_core_tb NOT OK");
      $finish;
    end
  end

  task automatic add_op(opcode_t op, logic signed [31:0] word);
    deque_op_t item;
    item.op   = op;
    item.word = word;
    op_backlog = {op_backlog, item};
    queued_total++;
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic opcode_t pick_push();
    return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
  endfunction

  function automatic opcode_t pick_pop();
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  // apb write of the mode register followed by a read back
  task automatic program_mode(logic [1:0] m);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MODE_ADDR;
    cfg_pwdata  <= {30'd0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    shadow_mode = m;
    mode_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[1:0] !== m) report_mismatch("mode read back", 32'(m), cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // hold the sender until every queued item has its result, then let the ring settle
  task automatic wait_quiet();
    while (accepted_total != queued_total || predicted_outcomes.size() > 0) @(posedge clk);
    repeat (DEPTH + 2) @(posedge clk);
  endtask

  // runs of pushes, pops and mixes so that full and empty are hit often
  task automatic add_random_phase(int n);
    int added;
    int len;
    added = 0;
    while (added < n) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          len = $urandom_range(1, 10);
          repeat (len) add_op(pick_push(), pick_word());
        end
        2, 3: begin
          len = $urandom_range(1, 10);
          repeat (len) add_op(pick_pop(), pick_word());
        end
        4: begin
          len = $urandom_range(1, 8);
          repeat (len) add_op(opcode_t'($urandom_range(0, 3)), pick_word());
        end
        default: begin
          len = 2 * (DEPTH + 1);
          repeat (DEPTH + 1) add_op(pick_push(), pick_word());
          repeat (DEPTH + 1) add_op(pick_pop(), pick_word());
        end
      endcase
      added += len;
    end
  endtask

  initial begin
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_empty = 1'b1;
    shadow_mode  = MODE_FREE;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    rst_n            = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // unrestricted: underflow on empty, fill to full with extremes, overflow, drain
    program_mode(MODE_FREE);
    add_op(OP_POP_FRONT, 32'sh7fff_ffff);
    add_op(OP_POP_REAR, 32'sh8000_0000);
    add_op(OP_PUSH_REAR, 32'sh7fff_ffff);
    add_op(OP_PUSH_FRONT, 32'sh8000_0000);
    add_op(OP_PUSH_FRONT, -32'sd1);
    add_op(OP_PUSH_REAR, '0);
    add_op(OP_PUSH_FRONT, 32'sh5555_5555);
    add_op(OP_PUSH_REAR, 32'shaaaa_aaaa);
    add_op(OP_PUSH_FRONT, 32'sh0000_0001);
    add_op(OP_PUSH_REAR, 32'sh1234_5678);
    add_op(OP_PUSH_FRONT, 32'sh0bad_f00d);
    add_op(OP_PUSH_REAR, -32'sd1);
    repeat (4) add_op(OP_POP_FRONT, '0);
    repeat (4) add_op(OP_POP_REAR, -32'sd1);
    add_op(OP_POP_REAR, '0);
    wait_quiet();

    // input restricted: push at the rear refused on empty and with content
    program_mode(MODE_IN_RESTR);
    add_op(OP_PUSH_REAR, 32'sh0000_0005);
    add_op(OP_PUSH_FRONT, 32'sh0000_0006);
    add_op(OP_PUSH_REAR, 32'sh0000_0007);
    add_op(OP_POP_FRONT, '0);
    wait_quiet();

    // output restricted: mode check wins over the empty check
    program_mode(MODE_OUT_RESTR);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_PUSH_REAR, 32'sh7654_3210);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_REAR, '0);
    wait_quiet();

    // random phases over every mode, with and without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       program_mode(MODE_SPARE);
        1:       program_mode(MODE_FREE);
        2:       program_mode(MODE_IN_RESTR);
        3:       program_mode(MODE_OUT_RESTR);
        default: program_mode(2'($urandom_range(0, 3)));
      endcase
      src_idle_on  = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      add_random_phase(PHASE_ITEMS);
      wait_quiet();
    end

    $display("%0d operations in, %0d results checked over %0d mode writes", accepted_total,
             results_checked, mode_writes);
    $display("ok %0d, overflow %0d, underflow %0d, rejected %0d", status_tally[ST_OK],
             status_tally[ST_OVERFLOW], status_tally[ST_UNDERFLOW], status_tally[ST_REJECTED]);
    if (mismatches == 0 && predicted_outcomes.size() == 0) begin
      $display("circular_deque_core_tb OK");
    end else begin
      $display("circular_deque_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/dq_ring.sv
rtl/dq_ctrl.sv
rtl/circular_deque_core.sv
tb/circular_deque_core_tb.sv
